FILE: design/bdkq_pkg.sv
// Shared types, constants and a helper function for the button debounce key queue.
package bdkq_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int CODE_W      = 3;
    localparam int RING_SLOTS  = 4;
    localparam int IDX_W       = $clog2(RING_SLOTS);

    // Request kinds carried in the req_type field.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [NUM_BUTTONS-1:0] t_pins;
    typedef logic [CODE_W-1:0]      t_code;

    localparam t_idx LAST_IDX = t_idx'(RING_SLOTS - 1);

    typedef struct packed {
        logic  req_type;
        t_pins raw_pins;
    } t_req;

    typedef struct packed {
        t_pins pressed_mask;
        logic  click;
        logic  got_button;
        t_code button_code;
    } t_rsp;

    // Control from the top level to the code ring.
    typedef struct packed {
        logic  push_en;
        logic  pop_en;
        t_pins push_mask;
    } t_ring_ctl;

    function automatic t_idx ring_next(input t_idx idx);
        t_idx nxt;
        if (idx == LAST_IDX) begin
            nxt = '0;
        end else begin
            nxt = idx + t_idx'(1);
        end
        return nxt;
    endfunction

endpackage

FILE: design/button_debounce_key_queue_top.sv
// Top level of the button debouncer with its queue of pressed-button codes.
//
// Each input transaction is either a sample tick carrying the five active-low
// pin levels, or a request to take the oldest queued button code. Every
// transaction yields exactly one result transaction. A tick reports the
// buttons whose debounced state went from released to pressed and queues
// their codes (up 0, right 1, left 2, center 3, down 4, in that order); a
// pop reports whether a code was waiting and which one. The block takes one
// transaction per clock cycle when the result side keeps up. A transaction
// is held in the input register while the debounce and queue logic settles,
// and its result enters the output register once that register is free or
// its current result is being taken. The output register lets a new
// transaction enter while an earlier result still waits to be taken. The
// queue holds RING_SLOTS-1 codes; codes pressed while it is full are lost.
module button_debounce_key_queue_top
    import bdkq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    logic      r_in_valid, r_out_valid;
    t_req      r_in;
    t_rsp      r_out, n_out;
    logic      s_advance, s_is_tick, s_got;
    t_pins     s_pressed;
    t_code     s_code;
    t_ring_ctl s_ring_ctl;

    // The held transaction moves on whenever the output register is free or
    // its current result is being taken in this same cycle.
    assign s_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || s_advance;
    assign s_is_tick  = (r_in.req_type == REQ_TICK);

    bdkq_debounce u_debounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick_en  (s_advance && s_is_tick),
        .i_raw_pins (r_in.raw_pins),
        .o_pressed  (s_pressed)
    );

    always_comb begin
        s_ring_ctl.push_en   = s_advance && s_is_tick;
        s_ring_ctl.pop_en    = s_advance && (r_in.req_type == REQ_POP);
        s_ring_ctl.push_mask = s_pressed;
    end

    bdkq_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ring_ctl),
        .o_got   (s_got),
        .o_code  (s_code)
    );

    // A tick reports presses only; a pop reports the queue only. The code is
    // forced to zero when the queue was empty, since that slot may be stale.
    always_comb begin
        n_out = '0;
        if (s_is_tick) begin
            n_out.pressed_mask = s_pressed;
            n_out.click        = |s_pressed;
        end else begin
            n_out.got_button  = s_got;
            n_out.button_code = s_got ? s_code : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (s_advance) begin
                r_in_valid <= 1'b0;
            end
            if (s_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (s_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/bdkq_debounce.sv
// Vertical two-bit counter debouncer for the five button pins.
module bdkq_debounce
    import bdkq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_tick_en,
    input  t_pins i_raw_pins,
    output t_pins o_pressed
);

    t_pins r_cnt_hi, r_cnt_lo, r_last_sample, r_stable;
    t_pins n_cnt_hi, n_cnt_lo, n_stable;
    t_pins s_sample, s_diff, s_hi_clr, s_lo_clr, s_nz;

    always_comb begin
        // Pins are active low; a pressed button reads as one here.
        s_sample = ~i_raw_pins;
        s_diff   = s_sample ^ r_last_sample;
        s_hi_clr = r_cnt_hi & ~s_diff;
        s_lo_clr = r_cnt_lo & ~s_diff;
        // Decrement every counter, wrapping from zero back to three.
        n_cnt_hi = s_hi_clr ^ ~s_lo_clr;
        n_cnt_lo = ~s_lo_clr;
        s_nz     = n_cnt_hi | n_cnt_lo;
        n_stable = (r_stable & s_nz) | (s_sample & ~s_nz);
        o_pressed = n_stable & ~r_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_hi      <= '0;
            r_cnt_lo      <= '0;
            r_last_sample <= '0;
            r_stable      <= '0;
        end else if (i_tick_en) begin
            r_cnt_hi      <= n_cnt_hi;
            r_cnt_lo      <= n_cnt_lo;
            r_last_sample <= s_sample;
            r_stable      <= n_stable;
        end
    end

endmodule

FILE: design/bdkq_ring.sv
// Ring of button codes that takes several pushes per cycle and one pop.
module bdkq_ring
    import bdkq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_ctl i_ctl,
    output logic      o_got,
    output t_code     o_code
);

    t_code r_slot [RING_SLOTS];
    t_code n_slot [RING_SLOTS];
    t_idx  r_wr, r_rd, n_wr;

    // Codes enter in bit order; once the ring is full the rest are dropped.
    always_comb begin
        for (int j = 0; j < RING_SLOTS; j++) begin
            n_slot[j] = r_slot[j];
        end
        n_wr = r_wr;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (i_ctl.push_en && i_ctl.push_mask[b] && (ring_next(n_wr) != r_rd)) begin
                n_slot[n_wr] = t_code'(b);
                n_wr         = ring_next(n_wr);
            end
        end
    end

    assign o_got  = (r_rd != r_wr);
    assign o_code = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < RING_SLOTS; j++) begin
            r_slot[j] <= n_slot[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            r_wr <= n_wr;
            if (i_ctl.pop_en && o_got) begin
                r_rd <= ring_next(r_rd);
            end
        end
    end

endmodule

FILE: design/bdkq_checker.sv
// Port-level checks for the button debounce key queue, bound to its top level.
module bdkq_checker
    import bdkq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or vanished while stalled");

    // The click flag matches the pressed mask.
    a_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.click == (o_out_data.pressed_mask != '0)))
        else $error("click does not match pressed mask");

    // A result is either a tick report or a queue report, never both.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.pressed_mask != '0) |->
            !o_out_data.got_button && (o_out_data.button_code == '0))
        else $error("tick result carries queue data");

    // Without a code the code field is zero, and a code names a real button.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.got_button
            ? (o_out_data.button_code < t_code'(NUM_BUTTONS))
            : (o_out_data.button_code == '0)))
        else $error("bad button code");

    // No result appears out of reset without a transaction before it.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind button_debounce_key_queue_top bdkq_checker u_bdkq_checker (.*);
